// ===== rtl/gas_pkg.sv =====
package gas_pkg;

	localparam int MAX_ROWS = 16;
	localparam int MAX_COLS = 16;
	localparam int ROW_W    = 4;
	localparam int COL_W    = 4;
	localparam int CELL_AW  = ROW_W + COL_W;
	localparam int CELLS    = MAX_ROWS * MAX_COLS;
	localparam int DIM_W    = 5;
	localparam int CNT_W    = 9;
	localparam int G_W      = 9;
	localparam int H_W      = 5;
	localparam int F_W      = 10;
	localparam int SEQ_W    = 9;

	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_SEARCH = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	typedef enum logic [2:0] {
		ST_OBSTACLE   = 3'd0,
		ST_EMPTY      = 3'd1,
		ST_EXPANDED   = 3'd2,
		ST_DISCOVERED = 3'd3,
		ST_START      = 3'd4,
		ST_FINISH     = 3'd5
	} cell_state_t;

	typedef struct packed {
		logic [ROW_W-1:0] r;
		logic [COL_W-1:0] c;
		logic [G_W-1:0]   g;
		logic [F_W-1:0]   f;
		logic [SEQ_W-1:0] seq;
	} open_entry_t;

	typedef struct packed {
		logic               we;
		logic [CELL_AW-1:0] waddr;
		cell_state_t        wdata;
		logic               re;
		logic [CELL_AW-1:0] raddr;
	} cell_req_t;

	typedef struct packed {
		logic               we;
		logic [CELL_AW-1:0] waddr;
		open_entry_t        wdata;
		logic               re;
		logic [CELL_AW-1:0] raddr;
	} open_req_t;

	function automatic logic [CELL_AW-1:0] cell_addr(input logic [ROW_W-1:0] r,
			input logic [COL_W-1:0] c);
		return {r, c};
	endfunction

	// manhattan distance to the goal
	function automatic logic [H_W-1:0] manhattan(input logic [ROW_W-1:0] r,
			input logic [COL_W-1:0] c, input logic [ROW_W-1:0] gr,
			input logic [COL_W-1:0] gc);
		logic [ROW_W-1:0] dr;
		logic [COL_W-1:0] dc;
		dr = (r > gr) ? r - gr : gr - r;
		dc = (c > gc) ? c - gc : gc - c;
		return H_W'(dr) + H_W'(dc);
	endfunction

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] maxv);
		logic [DIM_W-1:0] res;
		if (v == '0) begin
			res = DIM_W'(1);
		end else if (v > maxv) begin
			res = maxv;
		end else begin
			res = v;
		end
		return res;
	endfunction

endpackage

// ===== rtl/gas_cell_store.sv =====
module gas_cell_store (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gas_pkg::cell_req_t   req,
	output gas_pkg::cell_state_t rdata
);
	import gas_pkg::*;

	cell_state_t      mem [CELLS];
	logic [CELLS-1:0] vld_q;
	cell_state_t      data_q;
	logic             hit_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			data_q <= mem[req.raddr];
		end
	end

	// a cell never written reads as empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			hit_q <= 1'b0;
		end else begin
			if (req.we) begin
				vld_q[req.waddr] <= 1'b1;
			end
			if (req.re) begin
				hit_q <= vld_q[req.raddr];
			end
		end
	end

	assign rdata = hit_q ? data_q : ST_EMPTY;

endmodule

// ===== rtl/gas_open_list.sv =====
module gas_open_list (
	input  logic                 clk,
	input  gas_pkg::open_req_t   req,
	output gas_pkg::open_entry_t rdata
);
	import gas_pkg::*;

	open_entry_t mem [CELLS];
	open_entry_t data_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			data_q <= mem[req.raddr];
		end
	end

	assign rdata = data_q;

endmodule

// ===== rtl/grid_astar_search_core.sv =====
// channel   dir  fields (lowest bit up)
// s_*       in   tuser: op[1:0]; tdata: row, col, blocked, goal_row, goal_col
// m_*       out  tdata: cell_state, found, expanded_count
// apb       in   0x0 rows_in_use, 0x4 cols_in_use
// load and read commands are taken back to back unless the output stalls
// a search holds the input side for its whole walk: each pop scans the open
// list through its single read port
// reset empties the grid at once through per-cell valid bits, no clearing pass
// a stalled output holds one result and one more waits behind it
module grid_astar_search_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // row, col, blocked, goal_row, goal_col
	input  logic [1:0]  s_tuser,   // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // cell_state, found, expanded_count
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import gas_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_PUSH0, S_SCAN, S_SCAN_END, S_MOVE, S_MOVE2, S_FIN,
		S_NRD, S_NWR, S_DONE
	} state_t;

	localparam logic [CNT_W-1:0] POPPED_MAX = '1;

	state_t state_q;

	logic [DIM_W-1:0] rows_q, cols_q;

	logic [ROW_W-1:0] sr_q, gr_q, nb_r_q;
	logic [COL_W-1:0] sc_q, gc_q, nb_c_q;
	logic [CNT_W-1:0] cnt_q, popped_q, idx_q;
	logic [SEQ_W-1:0] seq_q;
	logic             cmp_vld_q;
	logic [CELL_AW-1:0] cmp_idx_q, best_idx_q;
	open_entry_t      best_q;
	logic [1:0]       k_q;
	logic             nb_ok_q;
	logic             found_q;

	logic             s1_valid_q, s1_read_q, s1_inside_q, s1_found_q;
	logic [CNT_W-1:0] s1_count_q;

	logic             out_valid_q, out_found_q;
	cell_state_t      out_state_q;
	logic [CNT_W-1:0] out_count_q;

	cell_req_t   cell_req;
	open_req_t   open_req;
	cell_state_t cell_rdata;
	open_entry_t open_rdata;

	logic [1:0]       op;
	logic [ROW_W-1:0] row, goal_row;
	logic [COL_W-1:0] col, goal_col;
	logic             blocked;
	logic             cmd_on_grid, accept, out_free, at_goal, better, push;
	logic [CNT_W-1:0] last_idx;
	logic [DIM_W-1:0] nr, nc;
	logic             nb_ok;
	logic [G_W-1:0]   g_next;
	logic             cfg_wr;

	assign op       = s_tuser;
	assign row      = s_tdata[3:0];
	assign col      = s_tdata[7:4];
	assign blocked  = s_tdata[8];
	assign goal_row = s_tdata[12:9];
	assign goal_col = s_tdata[16:13];

	assign cmd_on_grid = (DIM_W'(row) < rows_q) && (DIM_W'(col) < cols_q);
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == S_IDLE) && (!s1_valid_q || out_free);
	assign accept   = s_tvalid && s_tready;

	assign last_idx = cnt_q - 1'b1;
	assign at_goal  = (best_q.r == gr_q) && (best_q.c == gc_q);
	assign better   = (open_rdata.f < best_q.f) ||
		((open_rdata.f == best_q.f) && (open_rdata.seq > best_q.seq));
	assign g_next   = best_q.g + 1'b1;
	assign push     = nb_ok_q && (cell_rdata == ST_EMPTY) && (cnt_q < CNT_W'(CELLS));

	// neighbour order: up, left, down, right
	always_comb begin
		nr    = DIM_W'(best_q.r);
		nc    = DIM_W'(best_q.c);
		nb_ok = 1'b1;
		unique case (k_q)
			2'd0: begin
				nr    = DIM_W'(best_q.r) - 1'b1;
				nb_ok = (best_q.r != '0);
			end
			2'd1: begin
				nc    = DIM_W'(best_q.c) - 1'b1;
				nb_ok = (best_q.c != '0);
			end
			2'd2: nr = DIM_W'(best_q.r) + 1'b1;
			default: nc = DIM_W'(best_q.c) + 1'b1;
		endcase
		nb_ok = nb_ok && (nr < rows_q) && (nc < cols_q);
	end

	always_comb begin
		cell_req = '0;
		open_req = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept && op == OP_LOAD && cmd_on_grid) begin
					cell_req.we    = 1'b1;
					cell_req.waddr = cell_addr(row, col);
					cell_req.wdata = blocked ? ST_OBSTACLE : ST_EMPTY;
				end
				if (accept && op == OP_READ) begin
					cell_req.re    = 1'b1;
					cell_req.raddr = cell_addr(row, col);
				end
			end
			S_PUSH0: begin
				cell_req.we    = 1'b1;
				cell_req.waddr = cell_addr(sr_q, sc_q);
				cell_req.wdata = ST_DISCOVERED;
				open_req.we    = 1'b1;
				open_req.waddr = '0;
				open_req.wdata = '{r: sr_q, c: sc_q, g: '0,
					f: F_W'(manhattan(sr_q, sc_q, gr_q, gc_q)), seq: '0};
			end
			S_SCAN: begin
				open_req.re    = (cnt_q != '0);
				open_req.raddr = idx_q[CELL_AW-1:0];
			end
			S_MOVE: begin
				cell_req.we = 1'b1;
				if (at_goal) begin
					cell_req.waddr = cell_addr(sr_q, sc_q);
					cell_req.wdata = ST_START;
				end else begin
					cell_req.waddr = cell_addr(best_q.r, best_q.c);
					cell_req.wdata = ST_EXPANDED;
					open_req.re    = 1'b1;
					open_req.raddr = last_idx[CELL_AW-1:0];
				end
			end
			S_MOVE2: begin
				// fill the hole left by the popped entry with the last one
				open_req.we    = 1'b1;
				open_req.waddr = best_idx_q;
				open_req.wdata = open_rdata;
			end
			S_FIN: begin
				cell_req.we    = 1'b1;
				cell_req.waddr = cell_addr(gr_q, gc_q);
				cell_req.wdata = ST_FINISH;
			end
			S_NRD: begin
				cell_req.re    = nb_ok;
				cell_req.raddr = cell_addr(nr[ROW_W-1:0], nc[COL_W-1:0]);
			end
			S_NWR: begin
				if (push) begin
					cell_req.we    = 1'b1;
					cell_req.waddr = cell_addr(nb_r_q, nb_c_q);
					cell_req.wdata = ST_DISCOVERED;
					open_req.we    = 1'b1;
					open_req.waddr = cnt_q[CELL_AW-1:0];
					open_req.wdata = '{r: nb_r_q, c: nb_c_q, g: g_next,
						f: F_W'(g_next) + F_W'(manhattan(nb_r_q, nb_c_q, gr_q, gc_q)),
						seq: seq_q};
				end
			end
			default: ;
		endcase
	end

	gas_cell_store u_cells (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cell_req),
		.rdata  (cell_rdata)
	);

	gas_open_list u_open (
		.clk   (clk),
		.req   (open_req),
		.rdata (open_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			seq_q       <= '0;
			popped_q    <= '0;
			idx_q       <= '0;
			cmp_vld_q   <= 1'b0;
			k_q         <= '0;
			found_q     <= 1'b0;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q <= s1_valid_q;
				if (s1_valid_q) begin
					out_state_q <= (s1_read_q && s1_inside_q) ? cell_rdata : ST_OBSTACLE;
					out_found_q <= s1_found_q;
					out_count_q <= s1_count_q;
				end
			end

			if (cmp_vld_q && (cmp_idx_q == '0 || better)) begin
				best_q     <= open_rdata;
				best_idx_q <= cmp_idx_q;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						s1_valid_q  <= (op != OP_SEARCH);
						s1_read_q   <= (op == OP_READ);
						s1_inside_q <= cmd_on_grid;
						s1_found_q  <= 1'b0;
						s1_count_q  <= '0;
						if (op == OP_SEARCH) begin
							sr_q     <= row;
							sc_q     <= col;
							gr_q     <= goal_row;
							gc_q     <= goal_col;
							cnt_q    <= '0;
							seq_q    <= '0;
							popped_q <= '0;
							found_q  <= 1'b0;
							state_q  <= cmd_on_grid ? S_PUSH0 : S_DONE;
						end
					end else if (out_free) begin
						s1_valid_q <= 1'b0;
					end
				end
				S_PUSH0: begin
					cnt_q     <= CNT_W'(1);
					seq_q     <= SEQ_W'(1);
					idx_q     <= '0;
					cmp_vld_q <= 1'b0;
					state_q   <= S_SCAN;
				end
				S_SCAN: begin
					if (cnt_q == '0) begin
						state_q <= S_DONE;
					end else begin
						cmp_vld_q <= 1'b1;
						cmp_idx_q <= idx_q[CELL_AW-1:0];
						if (idx_q == last_idx) begin
							state_q <= S_SCAN_END;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				S_SCAN_END: begin
					cmp_vld_q <= 1'b0;
					state_q   <= S_MOVE;
				end
				S_MOVE: begin
					if (popped_q != POPPED_MAX) begin
						popped_q <= popped_q + 1'b1;
					end
					state_q <= at_goal ? S_FIN : S_MOVE2;
				end
				S_MOVE2: begin
					cnt_q   <= last_idx;
					k_q     <= '0;
					state_q <= S_NRD;
				end
				S_FIN: begin
					found_q <= 1'b1;
					state_q <= S_DONE;
				end
				S_NRD: begin
					nb_ok_q <= nb_ok;
					nb_r_q  <= nr[ROW_W-1:0];
					nb_c_q  <= nc[COL_W-1:0];
					state_q <= S_NWR;
				end
				S_NWR: begin
					if (push) begin
						cnt_q <= cnt_q + 1'b1;
						seq_q <= seq_q + 1'b1;
					end
					k_q <= k_q + 1'b1;
					if (k_q == 2'd3) begin
						idx_q     <= '0;
						cmp_vld_q <= 1'b0;
						state_q   <= S_SCAN;
					end else begin
						state_q <= S_NRD;
					end
				end
				S_DONE: begin
					// s1 is always free here, it drained when the search was taken
					s1_valid_q  <= 1'b1;
					s1_read_q   <= 1'b0;
					s1_inside_q <= 1'b0;
					s1_found_q  <= found_q;
					s1_count_q  <= popped_q;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_count_q, out_found_q, out_state_q};

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= DIM_W'(MAX_ROWS);
			cols_q <= DIM_W'(MAX_COLS);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_ROWS: rows_q <= clamp_dim(pwdata[DIM_W-1:0], DIM_W'(MAX_ROWS));
				REG_COLS: cols_q <= clamp_dim(pwdata[DIM_W-1:0], DIM_W'(MAX_COLS));
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_ROWS: prdata = 32'(rows_q);
			REG_COLS: prdata = 32'(cols_q);
			default:  prdata = '0;
		endcase
	end

endmodule

// ===== test/grid_astar_search_checker.sv =====
module grid_astar_search_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import gas_pkg::*;

	typedef struct packed {
		logic [8:0] expanded_count;
		logic       found;
		cell_state_t cell_state;
	} walk_result_t;

	typedef struct {
		int r;
		int c;
		int g;
		int h;
		int seq;
	} frontier_t;

	cell_state_t  grid[CELLS];
	frontier_t    frontier[CELLS];
	int           frontier_len;
	int           next_seq;
	int           rows_used;
	int           cols_used;
	walk_result_t expected_results[$];

	assign pending = expected_results.size();

	function automatic int fit_dim(logic [4:0] v, int maxv);
		if (v == 0) return 1;
		if (v > maxv) return maxv;
		return v;
	endfunction

	function automatic bit on_grid(int r, int c);
		return r >= 0 && c >= 0 && r < rows_used && c < cols_used;
	endfunction

	function automatic int abs_gap(int a, int b);
		return a > b ? a - b : b - a;
	endfunction

	function automatic void enqueue_cell(int r, int c, int g, int gr, int gc);
		if (frontier_len >= CELLS) return;
		frontier[frontier_len] = '{r, c, g, abs_gap(r, gr) + abs_gap(c, gc), next_seq};
		frontier_len++;
		next_seq++;
		grid[r * MAX_COLS + c] = ST_DISCOVERED;
	endfunction

	function automatic walk_result_t predict_walk(int sr, int sc, int gr, int gc);
		walk_result_t res;
		frontier_t cur;
		int best;
		int popped;
		int nr;
		int nc;
		int dr[4] = '{-1, 0, 1, 0};
		int dc[4] = '{0, -1, 0, 1};
		res = '0;
		popped = 0;
		frontier_len = 0;
		next_seq = 0;
		if (!on_grid(sr, sc)) return res;
		enqueue_cell(sr, sc, 0, gr, gc);
		while (frontier_len > 0) begin
			best = 0;
			for (int i = 1; i < frontier_len; i++) begin
				if (frontier[i].g + frontier[i].h < frontier[best].g + frontier[best].h ||
						(frontier[i].g + frontier[i].h == frontier[best].g + frontier[best].h
						&& frontier[i].seq > frontier[best].seq))
					best = i;
			end
			cur = frontier[best];
			frontier_len--;
			frontier[best] = frontier[frontier_len];
			if (popped < 511) popped++;
			grid[cur.r * MAX_COLS + cur.c] = ST_EXPANDED;
			if (cur.r == gr && cur.c == gc) begin
				grid[sr * MAX_COLS + sc] = ST_START;
				grid[gr * MAX_COLS + gc] = ST_FINISH;
				res.found = 1'b1;
				res.expanded_count = 9'(popped);
				return res;
			end
			for (int k = 0; k < 4; k++) begin
				nr = cur.r + dr[k];
				nc = cur.c + dc[k];
				if (on_grid(nr, nc) && grid[nr * MAX_COLS + nc] == ST_EMPTY)
					enqueue_cell(nr, nc, cur.g + 1, gr, gc);
			end
		end
		res.expanded_count = 9'(popped);
		return res;
	endfunction

	function automatic walk_result_t predict_command(logic [1:0] op, logic [23:0] d);
		walk_result_t res;
		int r;
		int c;
		r = d[3:0];
		c = d[7:4];
		res = '0;
		unique case (op)
			OP_LOAD: begin
				if (on_grid(r, c)) grid[r * MAX_COLS + c] = d[8] ? ST_OBSTACLE : ST_EMPTY;
			end
			OP_SEARCH: res = predict_walk(r, c, d[12:9], d[16:13]);
			OP_READ: begin
				if (on_grid(r, c)) res.cell_state = grid[r * MAX_COLS + c];
			end
			default: ;
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		walk_result_t got;
		walk_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < CELLS; i++) grid[i] = ST_EMPTY;
			rows_used = 16;
			cols_used = 16;
			fail_count = 0;
			expected_results.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_ROWS) rows_used = fit_dim(pwdata[4:0], MAX_ROWS);
				else cols_used = fit_dim(pwdata[4:0], MAX_COLS);
			end
			if (s_tvalid && s_tready)
				expected_results = {expected_results, predict_command(s_tuser, s_tdata)};
			if (m_tvalid && m_tready) begin
				got = m_tdata[12:0];
				if (expected_results.size() == 0) begin
					$error("result transaction with nothing expected: %h", m_tdata);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (got.cell_state !== want.cell_state) begin
						$error("cell_state expected %0d actual %0d", want.cell_state, got.cell_state);
						fail_count++;
					end
					if (got.found !== want.found) begin
						$error("found expected %0d actual %0d", want.found, got.found);
						fail_count++;
					end
					if (got.expanded_count !== want.expanded_count) begin
						$error("expanded_count expected %0d actual %0d",
							want.expanded_count, got.expanded_count);
						fail_count++;
					end
				end
			end
		end
	end
endmodule

// ===== test/tb_grid_astar_search_core.sv =====
module tb_grid_astar_search_core;
	timeunit 1ns;
	timeprecision 1ps;
	import gas_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // row, col, blocked, goal_row, goal_col
	logic [1:0]  s_tuser;   // op
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // cell_state, found, expanded_count
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          fail_count;
	int          pending;
	int          quiet_cycles;
	bit          stall_busy;

	grid_astar_search_core dut (.*);

	grid_astar_search_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 45) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// random receiver stalls; some phases run with none
	always @(posedge clk) begin
		if (stall_busy) m_tready <= 1'b1;
		else m_tready <= (gap_len() == 0) || ($urandom_range(0, 3) == 0);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 300000) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send(logic [1:0] op, logic [3:0] r, logic [3:0] c, logic b,
			logic [3:0] gr, logic [3:0] gc);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {7'd0, gc, gr, b, c, r};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic write_dim(logic sel, logic [31:0] v);
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (40) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic random_item(int dens);
		int p;
		p = $urandom_range(0, 99);
		if (p < 55)
			send(OP_LOAD, 4'($urandom), 4'($urandom), $urandom_range(0, 99) < dens, 0, 0);
		else if (p < 75)
			send(OP_SEARCH, 4'($urandom), 4'($urandom), 0, 4'($urandom), 4'($urandom));
		else if (p < 97)
			send(OP_READ, 4'($urandom), 4'($urandom), 0, 0, 0);
		else
			send(OP_UNUSED, 4'($urandom), 4'($urandom), 1'($urandom), 4'($urandom),
				4'($urandom));
	endtask

	initial begin
		int dims[6][2] = '{'{16, 16}, '{1, 1}, '{0, 31}, '{5, 6}, '{16, 2}, '{3, 16}};
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		quiet_cycles = 0;
		stall_busy = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: corners, whole-grid walks, blocked start, bad goal, unused op
		send(OP_READ, 15, 15, 0, 0, 0);
		send(OP_SEARCH, 0, 0, 0, 15, 15);
		send(OP_READ, 0, 0, 0, 0, 0);
		send(OP_READ, 15, 15, 0, 0, 0);
		send(OP_SEARCH, 4, 4, 0, 4, 4);
		send(OP_READ, 4, 4, 0, 0, 0);
		send(OP_UNUSED, 15, 15, 1, 15, 15);
		for (int i = 0; i < 16; i++) send(OP_LOAD, 4'(i), 0, 0, 0, 0);
		send(OP_LOAD, 7, 7, 1, 0, 0);
		send(OP_READ, 7, 7, 0, 0, 0);
		send(OP_SEARCH, 7, 7, 0, 0, 3);
		write_dim(REG_ROWS, 3);
		write_dim(REG_COLS, 3);
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++) send(OP_LOAD, 4'(r), 4'(c), 0, 0, 0);
		send(OP_SEARCH, 0, 0, 0, 15, 15);
		send(OP_SEARCH, 5, 0, 0, 0, 0);
		send(OP_LOAD, 5, 5, 1, 0, 0);
		send(OP_READ, 5, 5, 0, 0, 0);
		for (int ph = 0; ph < 12; ph++) begin
			write_dim(REG_ROWS, dims[ph % 6][0]);
			write_dim(REG_COLS, dims[ph % 6][1]);
			stall_busy = (ph % 4 == 3);
			// even phases clear cells in cols 0-3, then scatter obstacles
			for (int r = 0; r < 16; r++)
				for (int c = 0; c < 16; c++)
					if (ph % 2 == 0 && r < dims[ph % 6][0] + 1 && c < 4)
						send(OP_LOAD, 4'(r), 4'(c), 0, 0, 0);
			repeat (54) random_item(ph % 3 == 0 ? 10 : 35);
		end
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (50) @(posedge clk);
		if (fail_count == 0) $display("Test completed successfully");
		else $display("Test completed with failures");
		$finish;
	end
endmodule
